// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mspid_pkg.sv =====
// ---------------------------------------------------------------------------
// mspid_pkg
// widths, constants, codes and shared types of the motor speed pid block
// ---------------------------------------------------------------------------
package mspid_pkg;

	// field widths
	localparam int PULSE_W = 16;
	localparam int MS_W    = 16;
	localparam int SPEED_W = 20;
	localparam int DUTY_W  = 8;
	localparam int GAIN_W  = 16;
	localparam int PPR_W   = 8;
	localparam int ERR_W   = 21;
	localparam int DIFF_W  = 22;
	localparam int INTEG_W = 40;
	localparam int ACC_W   = 64;

	// shared multiplier: signed a times unsigned b
	localparam int MA_W   = 22;
	localparam int MB_W   = 16;
	localparam int PROD_W = MA_W + MB_W + 1;

	// shared divider: left-aligned dividend, unsigned divisor
	localparam int DVD_W = 57;
	localparam int DVS_W = 24;
	localparam int CNT_W = 6;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// iteration counts of the two divisions
	localparam logic [CNT_W-1:0] SPD_ITERS  = CNT_W'(36);
	localparam logic [CNT_W-1:0] DER_ITERS  = CNT_W'(57);

	// arithmetic constants
	localparam logic [MB_W-1:0]    RPM_MS_SCALE = 16'd60000;
	localparam logic [SPEED_W-1:0] SPEED_MAX    = 20'hFFFFF;
	localparam logic signed [ACC_W-1:0] DUTY_SUM_MAX = 64'sd1044480000;
	localparam logic [DUTY_W-1:0]  DUTY_MAX     = 8'd255;
	// floor(x / 125) as (x * 33555) >> 22, exact for x below 2^15
	localparam logic [MB_W-1:0]    DUTY_RECIP   = 16'd33555;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd384;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd128;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd13;
	localparam logic [PPR_W-1:0]  PPR_RST    = 8'd20;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLOSED_LOOP = 3'd0,
		REG_TARGET      = 3'd1,
		REG_MANUAL      = 3'd2,
		REG_GAIN_P      = 3'd3,
		REG_GAIN_I      = 3'd4,
		REG_GAIN_D      = 3'd5,
		REG_PPR         = 3'd6
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_NUM,
		ST_MUL_DEN,
		ST_SPD_GO,
		ST_SPD_WAIT,
		ST_ERR,
		ST_MUL_EI,
		ST_INTEG,
		ST_P_SCALE,
		ST_I_LO,
		ST_I_HI,
		ST_D_SCALE1,
		ST_D_SCALE2,
		ST_D_GO,
		ST_D_WAIT,
		ST_CLAMP,
		ST_DUTY_MUL,
		ST_OUT
	} mspid_state_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] iters;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	// multiply by 1000 as shifts and subtracts
	function automatic logic signed [ACC_W-1:0] times1000(input logic signed [ACC_W-1:0] x);
		return (x <<< 10) - (x <<< 4) - (x <<< 3);
	endfunction

endpackage

// ===== src/mspid_div.sv =====
// ---------------------------------------------------------------------------
// mspid_div
// restoring divider, one quotient bit per cycle, shared by the speed and
// derivative divisions
// ---------------------------------------------------------------------------
module mspid_div (
	input  logic                clk,
	input  logic                arst_n,
	input  mspid_pkg::div_req_t req,
	output mspid_pkg::div_rsp_t rsp
);
	import mspid_pkg::*;

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DVS_W:0]   shifted;
	logic             fits;
	logic [DVS_W:0]   rem_next;

	// trial subtract of the divisor from the shifted remainder
	assign shifted  = {rem_q, quo_q[DVD_W-1]};
	assign fits     = shifted >= {1'b0, dvs_q};
	assign rem_next = fits ? shifted - {1'b0, dvs_q} : shifted;

	// iteration counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.iters;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_next[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = (cnt_q != '0);
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/motor_speed_pid_controller_top.sv =====
// ---------------------------------------------------------------------------
// motor_speed_pid_controller_top
// encoder window to speed in 1/16 rpm, then pid or manual pwm duty
//
// channel  dir  handshake         payload
// s_*      in   tvalid/tready     tdata: pulse_count, elapsed_ms
// m_*      out  tvalid/tready     tdata: duty, measured_speed; tuser: clamped
// cfg_*    in   cfg_wr_en         cfg_index, cfg_wdata
//
// closed loop adds the pid steps, a clamped sum skips the duty multiply;
// the bit-serial divider runs 36 (speed) and 57 (derivative) iterations
// s_tready is high only while the sequencer is idle
// a finished item waits in the output register; the sequencer stalls at
// its last step only if the previous item has not been taken yet
// arst_n resets the sequencer, configuration registers and pid state at once
// ---------------------------------------------------------------------------
module motor_speed_pid_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// [15:0] pulse_count, [31:16] elapsed_ms
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,
	// [7:0] duty, [27:8] measured_speed, [31:28] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,
	// [0] clamped
	output logic [0:0]                        m_tuser,
	input  logic                              cfg_wr_en,
	input  logic [mspid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mspid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import mspid_pkg::*;

	mspid_state_t state_q, state_d;

	// configuration registers
	logic                closed_loop_q;
	logic [SPEED_W-1:0]  target_q;
	logic [DUTY_W-1:0]   manual_q;
	logic [GAIN_W-1:0]   gain_p_q;
	logic [GAIN_W-1:0]   gain_i_q;
	logic [GAIN_W-1:0]   gain_d_q;
	logic [PPR_W-1:0]    ppr_q;

	// pid state
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_err_q;

	// item datapath
	logic [PULSE_W-1:0]        pulses_q;
	logic [MS_W-1:0]           ms_q;
	logic [31:0]               num_q;
	logic [SPEED_W-1:0]        speed_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   t_q;
	logic                      dneg_q;
	logic [DUTY_W-1:0]         duty_q;
	logic                      clamp_q;

	// shared multiplier
	logic signed [MA_W-1:0]    mul_a;
	logic [MB_W-1:0]           mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   prod_ext;

	// output register
	logic                      m_valid_q;
	logic [31:0]               m_data_q;
	logic                      m_user_q;

	// shared divider
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	// misc combinational values
	logic                      accept;
	logic                      out_free;
	logic [PPR_W-1:0]          ppr_eff;
	logic signed [ERR_W-1:0]   err_new;
	logic signed [INTEG_W:0]   integ_sum;
	logic signed [ACC_W-1:0]   t_mag;
	logic signed [ACC_W-1:0]   quot_ext;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign ppr_eff  = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
	assign err_new  = $signed({1'b0, target_q}) - $signed({1'b0, speed_q});
	assign prod_ext = ACC_W'(prod_q);
	assign integ_sum = $signed({integ_q[INTEG_W-1], integ_q}) + (INTEG_W+1)'(prod_q);
	assign t_mag    = t_q[ACC_W-1] ? -t_q : t_q;
	assign quot_ext = $signed({{(ACC_W-DVD_W){1'b0}}, div_rsp.quotient});

	mspid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, multiplier operands and divider requests
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		div_req  = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_MUL_NUM;
			end
			ST_MUL_NUM: begin
				mul_a   = $signed({{(MA_W-PULSE_W){1'b0}}, pulses_q});
				mul_b   = RPM_MS_SCALE;
				state_d = ST_MUL_DEN;
			end
			ST_MUL_DEN: begin
				mul_a   = $signed({{(MA_W-MS_W){1'b0}}, ms_q});
				mul_b   = {{(MB_W-PPR_W){1'b0}}, ppr_eff};
				state_d = ST_SPD_GO;
			end
			ST_SPD_GO: begin
				div_req.start    = 1'b1;
				div_req.iters    = SPD_ITERS;
				div_req.dividend = {num_q, 4'b0000, 21'b0};
				div_req.divisor  = prod_q[DVS_W-1:0];
				state_d          = ST_SPD_WAIT;
			end
			ST_SPD_WAIT: begin
				if (div_rsp.done) state_d = closed_loop_q ? ST_ERR : ST_OUT;
			end
			ST_ERR: begin
				state_d = ST_MUL_EI;
			end
			ST_MUL_EI: begin
				mul_a   = MA_W'(err_q);
				mul_b   = ms_q;
				state_d = ST_INTEG;
			end
			ST_INTEG: begin
				mul_a   = MA_W'(err_q);
				mul_b   = gain_p_q;
				state_d = ST_P_SCALE;
			end
			ST_P_SCALE: begin
				mul_a   = $signed({2'b00, integ_q[19:0]});
				mul_b   = gain_i_q;
				state_d = ST_I_LO;
			end
			ST_I_LO: begin
				mul_a   = MA_W'($signed(integ_q[INTEG_W-1:20]));
				mul_b   = gain_i_q;
				state_d = ST_I_HI;
			end
			ST_I_HI: begin
				mul_a   = diff_q;
				mul_b   = gain_d_q;
				state_d = ST_D_SCALE1;
			end
			ST_D_SCALE1: begin
				state_d = ST_D_SCALE2;
			end
			ST_D_SCALE2: begin
				state_d = ST_D_GO;
			end
			ST_D_GO: begin
				div_req.start    = 1'b1;
				div_req.iters    = DER_ITERS;
				div_req.dividend = t_mag[DVD_W-1:0];
				div_req.divisor  = {{(DVS_W-MS_W){1'b0}}, ms_q};
				state_d          = ST_D_WAIT;
			end
			ST_D_WAIT: begin
				if (div_rsp.done) state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (acc_q[ACC_W-1] || acc_q > DUTY_SUM_MAX) begin
					state_d = ST_OUT;
				end else begin
					// sum / 4096000: drop 2^15, then divide by 125 by reciprocal
					mul_a   = $signed({{(MA_W-15){1'b0}}, acc_q[29:15]});
					mul_b   = DUTY_RECIP;
					state_d = ST_DUTY_MUL;
				end
			end
			ST_DUTY_MUL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration registers and pid state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_loop_q <= 1'b1;
			target_q      <= '0;
			manual_q      <= '0;
			gain_p_q      <= GAIN_P_RST;
			gain_i_q      <= GAIN_I_RST;
			gain_d_q      <= GAIN_D_RST;
			ppr_q         <= PPR_RST;
			integ_q       <= '0;
			prev_err_q    <= '0;
		end else begin
			// integrator update with saturation at its width
			if (state_q == ST_INTEG) begin
				if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
					integ_q <= integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
					                              : {1'b0, {(INTEG_W-1){1'b1}}};
				end else begin
					integ_q <= integ_sum[INTEG_W-1:0];
				end
			end
			if (state_q == ST_D_SCALE2) prev_err_q <= err_q;
			// register writes; a setpoint write clears the integrator
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_CLOSED_LOOP: closed_loop_q <= cfg_wdata[0];
					REG_TARGET: begin
						target_q <= cfg_wdata[SPEED_W-1:0];
						integ_q  <= '0;
					end
					REG_MANUAL:      manual_q <= cfg_wdata[DUTY_W-1:0];
					REG_GAIN_P:      gain_p_q <= cfg_wdata[GAIN_W-1:0];
					REG_GAIN_I:      gain_i_q <= cfg_wdata[GAIN_W-1:0];
					REG_GAIN_D:      gain_d_q <= cfg_wdata[GAIN_W-1:0];
					REG_PPR:         ppr_q    <= cfg_wdata[PPR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * $signed({1'b0, mul_b});
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pulses_q <= s_tdata[15:0];
					ms_q     <= (s_tdata[31:16] == '0) ? MS_W'(1) : s_tdata[31:16];
				end
			end
			ST_MUL_DEN: begin
				num_q <= prod_q[31:0];
			end
			ST_SPD_WAIT: begin
				if (div_rsp.done) begin
					speed_q <= (div_rsp.quotient[35:20] != '0) ? SPEED_MAX
					                                          : div_rsp.quotient[19:0];
					duty_q  <= manual_q;
					clamp_q <= 1'b0;
				end
			end
			ST_ERR: begin
				err_q  <= err_new;
				diff_q <= DIFF_W'(err_new) - DIFF_W'(prev_err_q);
			end
			ST_P_SCALE: begin
				acc_q <= times1000(prod_ext);
			end
			ST_I_LO: begin
				acc_q <= acc_q + prod_ext;
			end
			ST_I_HI: begin
				acc_q <= acc_q + (prod_ext <<< 20);
			end
			ST_D_SCALE1: begin
				t_q <= times1000(prod_ext);
			end
			ST_D_SCALE2: begin
				t_q <= times1000(t_q);
			end
			ST_D_GO: begin
				dneg_q <= t_q[ACC_W-1];
			end
			ST_D_WAIT: begin
				if (div_rsp.done) acc_q <= dneg_q ? acc_q - quot_ext : acc_q + quot_ext;
			end
			ST_CLAMP: begin
				if (acc_q[ACC_W-1]) begin
					duty_q  <= '0;
					clamp_q <= 1'b1;
				end else if (acc_q > DUTY_SUM_MAX) begin
					duty_q  <= DUTY_MAX;
					clamp_q <= 1'b1;
				end
			end
			ST_DUTY_MUL: begin
				duty_q  <= prod_q[29:22];
				clamp_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_data_q <= {4'b0000, speed_q, duty_q};
			m_user_q <= clamp_q;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_user_q;

endmodule

// ===== src/mspid_chk.sv =====
// ---------------------------------------------------------------------------
// mspid_chk
// port-level checks of the motor speed pid block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mspid_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result holds its value
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")

	// one item at a time: busy right after an accept
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready right after accept")

	// a result never appears the cycle after an accept
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")

	// a clamped result sits at an end of the duty range
	`ASSERT_SAME(a_clamp_duty, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255, "clamped duty not at a bound")

endmodule

bind motor_speed_pid_controller_top mspid_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
